// File: sv/hrs_pkg.sv
`default_nettype none
package hrs_pkg;

	// report geometry
	localparam int SLOTS     = 6;
	localparam int MOD_BITS  = 8;
	localparam int NUM_LANES = MOD_BITS + 2 * SLOTS;

	// scancode constants
	localparam logic [7:0] BREAK_BIT   = 8'h80;
	localparam logic [7:0] EXT_PREFIX  = 8'hE0;
	localparam logic [7:0] ARROW_FIRST = 8'h4F;
	localparam logic [7:0] ARROW_LAST  = 8'h52;
	localparam logic [7:0] TABLE_SIZE  = 8'h40;

	localparam logic [7:0] ARROW_MAP [4] = '{8'h4D, 8'h4B, 8'h50, 8'h48};

	localparam logic [7:0] USAGE_MAP [64] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h1E, 8'h30, 8'h2E, 8'h20,
		8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24, 8'h25, 8'h26,
		8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1F, 8'h14,
		8'h16, 8'h2F, 8'h11, 8'h2D, 8'h15, 8'h2C, 8'h02, 8'h03,
		8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
		8'h1C, 8'h01, 8'h0E, 8'h0F, 8'h39, 8'h0C, 8'h0D, 8'h1A,
		8'h1B, 8'h2B, 8'h00, 8'h27, 8'h28, 8'h29, 8'h33, 8'h34,
		8'h35, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	// make code and extended flag per modifier bit; code zero is ignored
	localparam logic [7:0] MOD_CODE [MOD_BITS] = '{
		8'h1D, 8'h2A, 8'h38, 8'h00, 8'h1D, 8'h36, 8'h38, 8'h00
	};
	localparam logic MOD_EXT [MOD_BITS] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

	// one lane's finding: a code to send, with or without the E0 prefix
	typedef struct packed {
		logic       valid;
		logic       ext;
		logic [7:0] code;
	} lane_t;

	typedef struct packed {
		logic       ext;
		logic [7:0] code;
	} keycode_t;

	// translate a key usage into a set-1 make code; code zero is unmapped
	function automatic keycode_t map_usage(input logic [7:0] usage);
		keycode_t   r;
		logic [7:0] diff;
		diff   = usage - ARROW_FIRST;
		r.ext  = 1'b0;
		r.code = 8'h00;
		if (usage >= ARROW_FIRST && usage <= ARROW_LAST) begin
			r.ext  = 1'b1;
			r.code = ARROW_MAP[diff[1:0]];
		end else if (usage < TABLE_SIZE) begin
			r.code = USAGE_MAP[usage[5:0]];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: sv/hid_report_to_set1_scancodes.sv
// Channel  Dir  Fields (tdata low bit up)                             Other
// s_       in   modifiers, key_a, key_b, key_c, key_d, key_e, key_f  tvalid/tready
// m_       out  scan_byte                                            tlast = last_byte
//
// A report is decoded by twenty lanes in the cycle of its transfer and the
// findings are latched; the merge stage then sends one byte per cycle while
// m_ is not stalled, up to 32 scancode bytes per report.
// The next report is taken in the cycle its predecessor's last byte is registered.
// Reset clears the kept report and all pending output; a stalled m_ holds
// its byte while the merge stage waits.
`default_nettype none
module hid_report_to_set1_scancodes (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,   // modifiers, key_a .. key_f
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // scan_byte
	output logic             m_tlast    // last_byte
);
	import hrs_pkg::*;

	logic [MOD_BITS-1:0]    prev_mods_q;
	logic [SLOTS-1:0][7:0]  prev_keys_q;
	logic [MOD_BITS-1:0]    mods;
	logic [SLOTS-1:0][7:0]  keys;
	wire lane_t [NUM_LANES-1:0] lanes;
	logic                   busy;
	logic                   load;

	assign mods     = s_tdata[7:0];
	assign keys     = s_tdata[55:8];
	assign s_tready = !busy;
	assign load     = s_tvalid && s_tready;

	// modifier lanes: one edge per bit, break on release
	for (genvar m = 0; m < MOD_BITS; m++) begin : g_mods
		assign lanes[m] = '{
			valid: (prev_mods_q[m] ^ mods[m]) && (MOD_CODE[m] != 8'h00),
			ext:   MOD_EXT[m],
			code:  prev_mods_q[m] ? (MOD_CODE[m] | BREAK_BIT) : MOD_CODE[m]
		};
	end

	// press lanes over the new report, release lanes over the kept one
	for (genvar g = 0; g < SLOTS; g++) begin : g_keys
		hrs_key_lane u_press (
			.usage  (keys[g]),
			.others (prev_keys_q),
			.brk    (1'b0),
			.lane   (lanes[MOD_BITS + g])
		);
		hrs_key_lane u_release (
			.usage  (prev_keys_q[g]),
			.others (keys),
			.brk    (1'b1),
			.lane   (lanes[MOD_BITS + SLOTS + g])
		);
	end

	// keep the report for the next comparison
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mods_q <= '0;
			prev_keys_q <= '0;
		end else if (load) begin
			prev_mods_q <= mods;
			prev_keys_q <= keys;
		end
	end

	hrs_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.lanes    (lanes),
		.busy     (busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

// File: sv/hrs_key_lane.sv
`default_nettype none
module hrs_key_lane (
	input  wire logic [7:0]                     usage,
	input  wire logic [hrs_pkg::SLOTS-1:0][7:0] others,
	input  wire logic                           brk,
	output hrs_pkg::lane_t                      lane
);
	import hrs_pkg::*;

	logic     held;
	keycode_t kc;

	// a usage is held when any slot of the other report carries it
	always_comb begin
		held = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			if (others[i] == usage) held = 1'b1;
		end
	end

	// emit only for a nonempty, changed and mapped usage
	always_comb begin
		kc         = map_usage(usage);
		lane.valid = (usage != 8'h00) && !held && (kc.code != 8'h00);
		lane.ext   = kc.ext;
		lane.code  = brk ? (kc.code | BREAK_BIT) : kc.code;
	end

endmodule
`default_nettype wire

// File: sv/hrs_merge.sv
`default_nettype none
module hrs_merge (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   load,
	input  wire hrs_pkg::lane_t [hrs_pkg::NUM_LANES-1:0] lanes,
	output logic                                        busy,
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	output logic [7:0]                                  m_tdata,  // scan_byte
	output logic                                        m_tlast   // last_byte
);
	import hrs_pkg::*;

	lane_t [NUM_LANES-1:0] lane_q;
	logic [NUM_LANES-1:0]  pend_q;
	logic                  phase_q;
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  out_last_q;

	logic [NUM_LANES-1:0]  first;
	logic [NUM_LANES-1:0]  rest;
	lane_t                 cur;
	logic                  emit_prefix;
	logic                  lane_done;
	logic                  advance;
	logic [NUM_LANES-1:0]  valids;

	// pick the lowest pending lane
	always_comb begin
		first = pend_q & (~pend_q + 1'b1);
		rest  = pend_q & ~first;
		cur   = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			if (first[i]) cur = lane_q[i];
		end
		for (int i = 0; i < NUM_LANES; i++) begin
			valids[i] = lanes[i].valid;
		end
		emit_prefix = cur.ext && !phase_q;
		lane_done   = !emit_prefix;
		advance     = (|pend_q) && (!out_valid_q || m_tready);
	end

	// load findings, then walk them one byte per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				pend_q  <= valids;
				phase_q <= 1'b0;
			end else if (advance) begin
				if (lane_done) begin
					pend_q  <= rest;
					phase_q <= 1'b0;
				end else begin
					phase_q <= 1'b1;
				end
			end
			if (advance) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// hold lane findings and the output byte
	always_ff @(posedge clk) begin
		if (load) lane_q <= lanes;
		if (advance) begin
			out_byte_q <= emit_prefix ? EXT_PREFIX : cur.code;
			out_last_q <= lane_done && (rest == '0);
		end
	end

	// free up for the next report as the final byte moves to the output register
	assign busy     = (|pend_q) && !(advance && lane_done && (rest == '0));
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire
